// ===== rtl/kce_pkg.sv =====
// Shared types and constants for the k-means clustering engine.
package kce_pkg;

  localparam int POINTS_DEF   = 1024;
  localparam int DIMS_DEF     = 16;
  localparam int CLUSTERS_DEF = 6;

  localparam int COORD_W = 16;
  localparam int ITER_W  = 8;
  localparam int SEED_W  = 10;
  localparam int SEED_REGS = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [ITER_W-1:0] ITER_RESET = 8'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ITER  = 3'd0,
    CFG_SEED0 = 3'd1,
    CFG_SEED1 = 3'd2,
    CFG_SEED2 = 3'd3,
    CFG_SEED3 = 3'd4,
    CFG_SEED4 = 3'd5,
    CFG_SEED5 = 3'd6
  } kce_cfg_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;
  localparam logic ANS_FINISH = 1'b0;
  localparam logic ANS_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ASSIGN,
    ST_ASSIGN_WAIT,
    ST_SUMS,
    ST_NEXT_PT,
    ST_UPD_RD,
    ST_UPD_LOAD,
    ST_UPD_WAIT,
    ST_ROUND_END,
    ST_FINISH
  } kce_state_t;

endpackage

// ===== rtl/kce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kce_ram #(
  parameter int W = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kce_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module kce_div import kce_pkg::*; #(
  parameter int NW = 26,
  parameter int DVW = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NW-1:0]      dividend,
  input  logic [DVW-1:0]     divisor,
  output logic               done,
  output logic [COORD_W-1:0] quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic            active;
  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   mag;
  logic [NW-1:0]   quo;
  logic [DVW-1:0]  rem;
  logic [DVW-1:0]  dv;
  logic            neg;
  logic [DVW:0]    trial;
  logic            fits;
  logic [NW-1:0]   quo_signed;

  assign trial = {rem, mag[NW-1]};
  assign fits  = (trial >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNTW'(NW);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[NW-1];
      mag <= dividend[NW-1] ? (~dividend + 1'b1) : dividend;
      dv  <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (active) begin
      mag <= mag << 1;
      quo <= {quo[NW-2:0], fits};
      rem <= fits ? DVW'(trial - {1'b0, dv}) : DVW'(trial);
    end
  end

  assign quo_signed = neg ? (~quo + 1'b1) : quo;
  assign quotient   = quo_signed[COORD_W-1:0];

endmodule

// ===== rtl/kmeans_clustering_engine.sv =====
// Top level of the k-means clustering engine: load, seeding, Lloyd rounds and queries.
//
// Loads and queries are taken one per cycle while busy is low; a query answer appears on the
// result ports in the cycle after the query is taken. The coordinate that carries
// last_coordinate starts a clustering run, during which busy is high, and the finish result
// appears when the run ends. The run first seeds the centers from the points picked by the
// seed registers and then runs the Lloyd rounds. The finish result is on the ports in the
// cycle after the last round; with no complete points or zero rounds it comes in the very
// next cycle, counting from the one that took the last coordinate. The point store has one
// read port, so the distance terms are read one at a time, and each new center coordinate
// waits for the bit-serial divider. Results are strobed for one cycle and cannot be held off,
// so the receiver must take every strobe.
module kmeans_clustering_engine import kce_pkg::*; #(
  parameter int POINTS = POINTS_DEF,
  parameter int DIMS = DIMS_DEF,
  parameter int CLUSTERS = CLUSTERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 func,
  input  logic signed [15:0]   coordinate,
  input  logic                 last_coordinate,
  input  logic [9:0]           query_point,
  output logic                 strobe,
  output logic                 answer_kind,
  output logic [9:0]           point_index,
  output logic [2:0]           cluster,
  output logic [10:0]          points_loaded,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEED_W-1:0]    cfg_data
);

  localparam int DW   = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int CW   = $clog2(CLUSTERS);
  localparam int CD   = CLUSTERS * DIMS;
  localparam int CAW  = $clog2(CD);
  localparam int PIW  = $clog2(POINTS);
  localparam int PD   = POINTS * DIMS;
  localparam int AW   = $clog2(PD);
  localparam int PCW  = $clog2(POINTS + 1);
  localparam int SUMW = COORD_W + $clog2(POINTS);
  localparam int ACCW = 2 * COORD_W + 2 + DW;

  kce_state_t state, state_next;

  // Configuration registers.
  logic [ITER_W-1:0] iter;
  logic [SEED_W-1:0] seed [SEED_REGS];

  // Load counters and run bookkeeping.
  logic [AW-1:0]  lpos;
  logic [DW-1:0]  ld;
  logic [PCW-1:0] lpts;
  logic [PCW-1:0] lpts_after;
  logic           full;
  logic [PCW-1:0] n;
  logic           had_rounds;

  // Sequencer counters.
  logic [DW-1:0]     dd, dd_inc;
  logic [CW-1:0]     jj, jj_inc;
  logic [CAW-1:0]    cidx, cidx_inc;
  logic              dd_last, jj_last, cidx_last;
  logic [PIW-1:0]    pt;
  logic [AW-1:0]     pbase;
  logic [ITER_W-1:0] round;
  logic [PCW-1:0]    counts [CLUSTERS];
  logic [CLUSTERS-1:0] dead;

  // Distance pipeline.
  logic              a1_v, a1_first, a1_last;
  logic [CW-1:0]     a1_j;
  logic              a2_v, a2_first, a2_last;
  logic [CW-1:0]     a2_j;
  logic [2*COORD_W+1:0] sq;
  logic signed [COORD_W:0] diff;
  logic signed [2*COORD_W+1:0] prod;
  logic [ACCW-1:0]   acc, acc_sum;
  logic [ACCW-1:0]   best_d;
  logic [CW-1:0]     best;
  logic              best_valid;

  // Seed copy and sum pipelines.
  logic           i1_v;
  logic [CAW-1:0] i1_addr;
  logic           s1_v, s1_first;
  logic [CAW-1:0] s1_addr;

  // Query pipeline.
  logic           q_strobe, q_ok;
  logic [9:0]     q_idx;

  // Memory ports.
  logic               pt_we;
  logic [AW-1:0]      pt_raddr;
  logic [COORD_W-1:0] pt_rdata;
  logic               ct_we;
  logic [CAW-1:0]     ct_waddr;
  logic [COORD_W-1:0] ct_wdata, ct_rdata;
  logic               sm_we;
  logic [CAW-1:0]     sm_raddr;
  logic [SUMW-1:0]    sm_wdata, sm_rdata, pt_ext;
  logic               as_we;
  logic [CW-1:0]      as_rdata;

  logic               div_start, div_done;
  logic [COORD_W-1:0] div_q;

  logic               accept, run_go;
  logic [AW-1:0]      seedbase;
  logic [CAW-1:0]     bestbase;
  int                 sat_idx;

  assign accept   = start && !busy;
  assign run_go   = accept && (func == FUNC_LOAD) && last_coordinate;
  assign full     = (lpts == PCW'(POINTS));
  assign lpts_after = (!full && ld == DW'(DIMS - 1)) ? lpts + 1'b1 : lpts;

  assign dd_last   = (dd == DW'(DIMS - 1));
  assign jj_last   = (jj == CW'(CLUSTERS - 1));
  assign cidx_last = (cidx == CAW'(CD - 1));
  assign dd_inc    = dd_last ? '0 : dd + 1'b1;
  assign jj_inc    = dd_last ? (jj_last ? '0 : jj + 1'b1) : jj;
  assign cidx_inc  = cidx_last ? '0 : cidx + 1'b1;

  assign sat_idx  = (int'(seed[3'(jj)]) >= int'(n)) ? int'(n) - 1 : int'(seed[3'(jj)]);
  assign seedbase = AW'(sat_idx * DIMS);
  assign bestbase = CAW'(int'(best) * DIMS);
  assign pt_ext   = {{(SUMW-COORD_W){pt_rdata[COORD_W-1]}}, pt_rdata};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (run_go) begin
          state_next = (lpts_after == '0 || iter == '0) ? ST_FINISH : ST_INIT;
        end
      end
      ST_INIT: begin
        if (cidx_last) state_next = ST_ASSIGN;
      end
      ST_ASSIGN: begin
        if (cidx_last) state_next = ST_ASSIGN_WAIT;
      end
      ST_ASSIGN_WAIT: begin
        if (a2_v && a2_last && a2_j == CW'(CLUSTERS - 1)) state_next = ST_SUMS;
      end
      ST_SUMS: begin
        if (dd_last) state_next = ST_NEXT_PT;
      end
      ST_NEXT_PT: begin
        state_next = (PCW'(pt) + 1'b1 == n) ? ST_UPD_RD : ST_ASSIGN;
      end
      ST_UPD_RD: begin
        if (counts[jj] != '0) state_next = ST_UPD_LOAD;
        else if (jj_last) state_next = ST_ROUND_END;
      end
      ST_UPD_LOAD: begin
        state_next = ST_UPD_WAIT;
      end
      ST_UPD_WAIT: begin
        if (div_done) state_next = cidx_last ? ST_ROUND_END : ST_UPD_RD;
      end
      ST_ROUND_END: begin
        state_next = (round + 1'b1 == iter) ? ST_FINISH : ST_ASSIGN;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    busy      = (state != ST_IDLE);
    cfg_ready = 1'b1;
    pt_we     = (state == ST_IDLE) && accept && (func == FUNC_LOAD) && !full;
    pt_raddr  = (state == ST_INIT) ? seedbase + AW'(dd) : pbase + AW'(dd);
    ct_we     = i1_v || (state == ST_UPD_WAIT && div_done);
    ct_waddr  = i1_v ? i1_addr : cidx;
    ct_wdata  = i1_v ? pt_rdata : div_q;
    sm_raddr  = (state == ST_SUMS) ? bestbase + CAW'(dd) : cidx;
    sm_we     = s1_v;
    sm_wdata  = s1_first ? pt_ext : sm_rdata + pt_ext;
    as_we     = (state == ST_SUMS) && (dd == '0);
    div_start = (state == ST_UPD_LOAD);
    if (state == ST_FINISH) begin
      strobe      = 1'b1;
      answer_kind = ANS_FINISH;
      point_index = '0;
      cluster     = '0;
    end else begin
      strobe      = q_strobe;
      answer_kind = ANS_QUERY;
      point_index = q_idx;
      cluster     = q_ok ? 3'(as_rdata) : '0;
    end
    points_loaded = 11'(n);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= ITER_RESET;
      for (int k = 0; k < SEED_REGS; k++) seed[k] <= SEED_W'(k);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ITER:  iter    <= cfg_data[ITER_W-1:0];
        CFG_SEED0: seed[0] <= cfg_data;
        CFG_SEED1: seed[1] <= cfg_data;
        CFG_SEED2: seed[2] <= cfg_data;
        CFG_SEED3: seed[3] <= cfg_data;
        CFG_SEED4: seed[4] <= cfg_data;
        CFG_SEED5: seed[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state: FSM, counters, valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      lpos       <= '0;
      ld         <= '0;
      lpts       <= '0;
      n          <= '0;
      had_rounds <= 1'b0;
      dd         <= '0;
      jj         <= '0;
      cidx       <= '0;
      pt         <= '0;
      pbase      <= '0;
      round      <= '0;
      dead       <= '0;
      for (int k = 0; k < CLUSTERS; k++) counts[k] <= '0;
      a1_v       <= 1'b0;
      a2_v       <= 1'b0;
      i1_v       <= 1'b0;
      s1_v       <= 1'b0;
      q_strobe   <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      state    <= state_next;
      a1_v     <= (state == ST_ASSIGN);
      a2_v     <= a1_v;
      i1_v     <= (state == ST_INIT);
      s1_v     <= (state == ST_SUMS);
      q_strobe <= accept && (func == FUNC_QUERY);

      if (state_next == ST_ASSIGN && state != ST_ASSIGN) begin
        best_valid <= 1'b0;
      end else if (a2_v && a2_last && !dead[a2_j] && (!best_valid || acc_sum < best_d)) begin
        best_valid <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (run_go) begin
            n          <= lpts_after;
            had_rounds <= (iter != '0);
            lpos       <= '0;
            ld         <= '0;
            lpts       <= '0;
            dd         <= '0;
            jj         <= '0;
            cidx       <= '0;
            pt         <= '0;
            pbase      <= '0;
            round      <= '0;
            dead       <= '0;
            for (int k = 0; k < CLUSTERS; k++) counts[k] <= '0;
          end else if (pt_we) begin
            lpos <= lpos + 1'b1;
            ld   <= (ld == DW'(DIMS - 1)) ? '0 : ld + 1'b1;
            lpts <= lpts_after;
          end
        end
        ST_INIT, ST_ASSIGN: begin
          dd   <= dd_inc;
          jj   <= jj_inc;
          cidx <= cidx_inc;
        end
        ST_SUMS: begin
          dd <= dd_inc;
          if (dd_last) counts[best] <= counts[best] + 1'b1;
        end
        ST_NEXT_PT: begin
          dd   <= '0;
          jj   <= '0;
          cidx <= '0;
          if (PCW'(pt) + 1'b1 != n) begin
            pt    <= pt + 1'b1;
            pbase <= pbase + AW'(DIMS);
          end
        end
        ST_UPD_RD: begin
          if (counts[jj] == '0) begin
            // An empty cluster is retired for the rest of the run.
            dead[jj] <= 1'b1;
            dd       <= '0;
            jj       <= jj_last ? '0 : jj + 1'b1;
            cidx     <= jj_last ? '0 : cidx + CAW'(DIMS);
          end
        end
        ST_UPD_WAIT: begin
          if (div_done) begin
            dd   <= dd_inc;
            jj   <= jj_inc;
            cidx <= cidx_inc;
          end
        end
        ST_ROUND_END: begin
          round <= round + 1'b1;
          pt    <= '0;
          pbase <= '0;
          for (int k = 0; k < CLUSTERS; k++) counts[k] <= '0;
        end
        default: ;
      endcase
    end
  end

  // Payload pipeline registers.
  assign diff    = $signed({pt_rdata[COORD_W-1], pt_rdata}) -
                   $signed({ct_rdata[COORD_W-1], ct_rdata});
  assign prod    = diff * diff;
  assign acc_sum = (a2_first ? '0 : acc) + ACCW'(sq);

  always_ff @(posedge clk) begin
    a1_j     <= jj;
    a1_first <= (dd == '0);
    a1_last  <= dd_last;
    a2_j     <= a1_j;
    a2_first <= a1_first;
    a2_last  <= a1_last;
    sq       <= prod;
    if (a2_v) acc <= acc_sum;
    if (state_next == ST_ASSIGN && state != ST_ASSIGN) begin
      best <= '0;
    end else if (a2_v && a2_last && !dead[a2_j] && (!best_valid || acc_sum < best_d)) begin
      best   <= a2_j;
      best_d <= acc_sum;
    end
    i1_addr  <= cidx;
    s1_addr  <= sm_raddr;
    s1_first <= (counts[best] == '0);
    q_idx    <= query_point;
    q_ok     <= had_rounds && (int'(query_point) < int'(n));
  end

  kce_ram #(.W(COORD_W), .DEPTH(PD)) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (lpos),
    .wdata (coordinate),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  kce_ram #(.W(COORD_W), .DEPTH(CD)) u_center_ram (
    .clk   (clk),
    .we    (ct_we),
    .waddr (ct_waddr),
    .wdata (ct_wdata),
    .raddr (cidx),
    .rdata (ct_rdata)
  );

  kce_ram #(.W(SUMW), .DEPTH(CD)) u_sum_ram (
    .clk   (clk),
    .we    (sm_we),
    .waddr (s1_addr),
    .wdata (sm_wdata),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  kce_ram #(.W(CW), .DEPTH(POINTS)) u_assign_ram (
    .clk   (clk),
    .we    (as_we),
    .waddr (pt),
    .wdata (best),
    .raddr (PIW'(query_point)),
    .rdata (as_rdata)
  );

  kce_div #(.NW(SUMW), .DVW(PCW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sm_rdata),
    .divisor  (counts[jj]),
    .done     (div_done),
    .quotient (div_q)
  );

  // A query answer and a finish result never share a cycle.
  assert property (@(posedge clk) disable iff (rst) !(q_strobe && state == ST_FINISH))
    else $error("query answer collides with finish result");

  // The point store is written only while no run is in progress.
  assert property (@(posedge clk) disable iff (rst) pt_we |-> state == ST_IDLE)
    else $error("point store written during a run");

  // A retired cluster never receives members.
  assert property (@(posedge clk) disable iff (rst) state == ST_SUMS |-> !dead[best])
    else $error("point assigned to a dead cluster");

  // A divider start is always followed by the wait for its result.
  assert property (@(posedge clk) disable iff (rst) div_start |=> state == ST_UPD_WAIT)
    else $error("divider started outside the update sequence");

endmodule

// ===== verif/kmeans_clustering_engine_tb.sv =====
// Self-checking testbench for the k-means clustering engine: directed and random load/query runs.
module kmeans_clustering_engine_tb;
  import kce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 1024;
  localparam int NDIM = 16;
  localparam int NCLU = 6;
  localparam int STORE_DEPTH = NPTS * NDIM;
  localparam int STALL_LIMIT = 1000000;
  localparam int TOTAL_ITEMS = 1950;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    logic        kind;
    logic [9:0]  idx;
    logic [2:0]  clu;
    logic [10:0] loaded;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic func = FUNC_LOAD;
  logic signed [15:0] coordinate = '0;
  logic last_coordinate = 1'b0;
  logic [9:0] query_point = '0;
  logic strobe;
  logic answer_kind;
  logic [9:0] point_index;
  logic [2:0] cluster;
  logic [10:0] points_loaded;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SEED_W-1:0] cfg_data = '0;

  kmeans_clustering_engine uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .coordinate(coordinate), .last_coordinate(last_coordinate), .query_point(query_point),
    .strobe(strobe), .answer_kind(answer_kind), .point_index(point_index),
    .cluster(cluster), .points_loaded(points_loaded), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the engine state.
  logic [7:0] iter_rounds;
  logic [9:0] seed_idx [NCLU];
  int point_mem [STORE_DEPTH];
  int center_mem [NCLU*NDIM];
  logic [2:0] member_of [NPTS];
  int load_pos;
  int point_count;

  answer_t answers [$];
  answer_t got_answer;
  int errors = 0;
  int sent_items = 0;
  int stall_cycles = 0;
  bit calm = 1'b0;

  function automatic longint unsigned sq_distance(int p, int c);
    longint unsigned acc;
    longint diff;
    acc = 0;
    for (int d = 0; d < NDIM; d++) begin
      diff = longint'(point_mem[p*NDIM+d]) - longint'(center_mem[c*NDIM+d]);
      acc += longint'(diff * diff);
    end
    return acc;
  endfunction

  task automatic lloyd_run();
    int n;
    int s;
    int best;
    longint unsigned best_d;
    longint unsigned dj;
    logic [NCLU-1:0] dead;
    longint sums [NCLU*NDIM];
    int counts [NCLU];
    n = point_count;
    if (n == 0) return;
    for (int j = 0; j < NCLU; j++) begin
      s = (seed_idx[j] >= n) ? n - 1 : seed_idx[j];
      for (int d = 0; d < NDIM; d++) center_mem[j*NDIM+d] = point_mem[s*NDIM+d];
    end
    dead = '0;
    for (int i = 0; i < n; i++) member_of[i] = 3'd0;
    for (int it = 0; it < iter_rounds; it++) begin
      for (int i = 0; i < n; i++) begin
        best = -1;
        best_d = 0;
        for (int j = 0; j < NCLU; j++) begin
          if (!dead[j]) begin
            dj = sq_distance(i, j);
            if (best < 0 || dj < best_d) begin
              best = j;
              best_d = dj;
            end
          end
        end
        if (best < 0) best = 0;
        member_of[i] = 3'(best);
      end
      for (int k = 0; k < NCLU*NDIM; k++) sums[k] = 0;
      for (int j = 0; j < NCLU; j++) counts[j] = 0;
      for (int i = 0; i < n; i++) begin
        counts[member_of[i]]++;
        for (int d = 0; d < NDIM; d++) sums[member_of[i]*NDIM+d] += point_mem[i*NDIM+d];
      end
      for (int j = 0; j < NCLU; j++) begin
        if (counts[j] == 0) begin
          dead[j] = 1'b1;
        end else begin
          // Signed division truncates toward zero.
          for (int d = 0; d < NDIM; d++)
            center_mem[j*NDIM+d] = int'(sums[j*NDIM+d] / longint'(counts[j]));
        end
      end
    end
  endtask

  task automatic model_item(logic f, logic signed [15:0] c, logic l, logic [9:0] q);
    answer_t a;
    if (f == FUNC_LOAD) begin
      if (load_pos < STORE_DEPTH) begin
        point_mem[load_pos] = c;
        load_pos++;
      end
      if (l) begin
        point_count = load_pos / NDIM;
        load_pos = 0;
        lloyd_run();
        a = '{ANS_FINISH, 10'd0, 3'd0, 11'(point_count)};
        answers = {answers, a};
      end
    end else begin
      a = '{ANS_QUERY, q, 3'd0, 11'(point_count)};
      if (q < point_count) a.clu = member_of[q];
      answers = {answers, a};
    end
  endtask

  task automatic send_item(logic f, logic signed [15:0] c, logic l, logic [9:0] q);
    if (!calm) begin
      while ($urandom_range(99) < 31) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    cfg_valid <= 1'b0;
    func <= f;
    coordinate <= c;
    last_coordinate <= l;
    query_point <= q;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    model_item(f, c, l, q);
    sent_items++;
  endtask

  // Lowers start, waits out every pending result and then the engine's tail.
  task automatic wait_idle();
    start <= 1'b0;
    cfg_valid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SEED_W-1:0] data);
    if (!calm) begin
      while ($urandom_range(99) < 31) begin
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
    end
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ITER) iter_rounds = data[7:0];
    else if (idx <= CFG_SEED5) seed_idx[idx - CFG_SEED0] = data;
  endtask

  task automatic send_query(logic [9:0] q);
    send_item(FUNC_QUERY, 16'($urandom), 1'($urandom), q);
  endtask

  task automatic random_query();
    if (point_count > 0 && $urandom_range(9) < 8) send_query(10'($urandom_range(point_count - 1)));
    else send_query(10'($urandom_range(1023)));
  endtask

  // Loads npts points plus extra coordinates of a partial point; the final one carries the
  // last mark. Grouped sets scatter points around a few random centers.
  task automatic load_set(int npts, int extra, bit grouped, bit mix_queries);
    int total;
    int g;
    logic signed [15:0] c;
    logic signed [15:0] base [NCLU][NDIM];
    total = npts * NDIM + extra;
    if (total == 0) total = 1;
    for (int j = 0; j < NCLU; j++)
      for (int d = 0; d < NDIM; d++) base[j][d] = 16'($urandom);
    g = 0;
    for (int k = 0; k < total; k++) begin
      if (k % NDIM == 0) g = $urandom_range(NCLU - 1);
      if (grouped) c = base[g][k % NDIM] + 16'($signed($urandom_range(64)) - 32);
      else c = 16'($urandom);
      if (mix_queries && $urandom_range(9) == 0) random_query();
      send_item(FUNC_LOAD, c, k == total - 1, 10'($urandom));
    end
  endtask

  task automatic test_query_before_clustering();
    send_query(10'd0);
    send_query(10'd1023);
    send_item(FUNC_QUERY, 16'sh7fff, 1'b1, 10'h2aa);
    send_item(FUNC_QUERY, -16'sd32768, 1'b0, 10'h155);
    wait_idle();
  endtask

  task automatic test_reset_settings();
    load_set(6, 0, 1'b1, 1'b0);
    for (int i = 0; i < 6; i++) send_query(10'(i));
    wait_idle();
  endtask

  task automatic test_no_points();
    write_reg(CFG_ITER, 10'h3ff);
    wait_idle();
    send_item(FUNC_LOAD, 16'sh1234, 1'b1, 10'd0);
    send_query(10'd0);
    wait_idle();
  endtask

  task automatic test_zero_iterations();
    write_reg(CFG_ITER, 10'h100);
    wait_idle();
    load_set(7, 0, 1'b0, 1'b0);
    send_query(10'd0);
    send_query(10'd6);
    send_query(10'd7);
    wait_idle();
  endtask

  // Equal seeds give equal centers: the lowest index wins every tie and the rest die.
  // A seed past the loaded points falls back to the last point.
  task automatic test_ties_and_dead_clusters();
    write_reg(CFG_ITER, 10'd3);
    for (int j = 0; j < 5; j++) write_reg(kce_cfg_t'(CFG_SEED0 + j), 10'd0);
    write_reg(CFG_SEED5, 10'd1023);
    write_reg(CFG_UNUSED, 10'h3ff);
    wait_idle();
    for (int k = 0; k < 4 * NDIM; k++)
      send_item(FUNC_LOAD, (k / NDIM) % 2 ? 16'sh7fff : -16'sd32768, k == 4*NDIM - 1, 10'd0);
    for (int i = 0; i < 4; i++) send_query(10'(i));
    wait_idle();
  endtask

  task automatic test_partial_point();
    write_reg(CFG_ITER, 10'd2);
    for (int j = 0; j < NCLU; j++) write_reg(kce_cfg_t'(CFG_SEED0 + j), 10'(j));
    wait_idle();
    load_set(6, 5, 1'b0, 1'b0);
    send_query(10'd5);
    send_query(10'd6);
    wait_idle();
  endtask

  task automatic test_random();
    int phase;
    int nq;
    phase = 0;
    while (sent_items < TOTAL_ITEMS) begin
      calm = (phase == 3);
      for (int r = 0; r <= CFG_UNUSED; r++) begin
        if ($urandom_range(2) == 0) begin
          if (r == CFG_ITER) begin
            if ($urandom_range(7) == 0) write_reg(CFG_ITER, 10'($urandom) & 10'h300);
            else write_reg(CFG_ITER, {2'($urandom), 8'($urandom_range(1, 4))});
          end else if ($urandom_range(1)) begin
            write_reg(r[CFG_IDX_W-1:0], 10'($urandom_range(11)));
          end else begin
            write_reg(r[CFG_IDX_W-1:0], 10'($urandom));
          end
        end
      end
      wait_idle();
      load_set($urandom_range(0, 11), ($urandom_range(3) == 0) ? $urandom_range(1, 15) : 0,
               $urandom_range(1), 1'b1);
      nq = $urandom_range(15, 40);
      for (int i = 0; i < nq; i++) random_query();
      wait_idle();
      phase++;
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (answers.size() == 0) begin
        $error("result with no transaction pending: kind %0d point %0d", answer_kind,
               point_index);
        errors++;
      end else begin
        got_answer = answers.pop_front();
        if (answer_kind !== got_answer.kind) begin
          $error("answer_kind: expected %0d, actual %0d", got_answer.kind, answer_kind);
          errors++;
        end
        if (point_index !== got_answer.idx) begin
          $error("point_index: expected %0d, actual %0d", got_answer.idx, point_index);
          errors++;
        end
        if (cluster !== got_answer.clu) begin
          $error("cluster: expected %0d, actual %0d", got_answer.clu, cluster);
          errors++;
        end
        if (points_loaded !== got_answer.loaded) begin
          $error("points_loaded: expected %0d, actual %0d", got_answer.loaded, points_loaded);
          errors++;
        end
      end
    end
  end

  // The stall counter restarts on any transaction on either channel or any result.
  always @(posedge clk) begin
    if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("kmeans_clustering_engine test failed");
      $finish;
    end
  end

  initial begin
    iter_rounds = ITER_RESET;
    for (int j = 0; j < NCLU; j++) seed_idx[j] = 10'(j);
    load_pos = 0;
    point_count = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_query_before_clustering();
    test_reset_settings();
    test_no_points();
    test_zero_iterations();
    test_ties_and_dead_clusters();
    test_partial_point();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && answers.size() == 0) begin
      $display("kmeans_clustering_engine test passed");
    end else begin
      $display("kmeans_clustering_engine test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kce_pkg.sv
rtl/kce_ram.sv
rtl/kce_div.sv
rtl/kmeans_clustering_engine.sv
verif/kmeans_clustering_engine_tb.sv
